FILE: rtl/s2lab_pkg.sv
// ----------------------------------------------------------------------------
// s2lab_pkg: shared types, constants and tables of the sRGB to L*a*b* pipeline
// Holds the sRGB gamma table (built at elaboration), the D65 XYZ matrix
// scaled by the reference white, and the knee function constants.
// ----------------------------------------------------------------------------
`default_nettype none

package s2lab_pkg;

  // widths of the internal fixed-point values
  localparam int LIN_W = 17;           // linear intensity, Q16 (0..65536)
  localparam int COEF_W = 16;          // matrix coefficient, Q16
  localparam int PROD_W = LIN_W + COEF_W;
  localparam int T_W = 34;             // t after clamping, Q32
  localparam int F_W = 21;             // knee output, Q20
  localparam int CBRT_STEPS = 21;      // one result bit per step

  typedef logic [LIN_W-1:0] lin_tab_t [256];
  typedef logic [COEF_W-1:0] coef_t;
  typedef logic [T_W-1:0] t_val_t;
  typedef logic [F_W-1:0] f_val_t;

  localparam logic [31:0] GAMMA_DEN = 32'd269025;

  // sRGB code to linear intensity, exact floor at 17 fraction bits then halved
  function automatic lin_tab_t build_lin_tab();
    lin_tab_t tab;
    logic [319:0] rhs;
    logic [319:0] den;
    logic [319:0] lhs;
    logic [31:0] n;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] mid;
    for (int c = 0; c < 256; c++) begin
      if (c <= 10) begin
        tab[c] = LIN_W'((c * 655360 + 16473) / 32946);
      end else begin
        n = 32'(1000 * c + 14025);
        rhs = 320'd1;
        den = 320'd1;
        for (int k = 0; k < 12; k++) begin
          rhs = rhs * 320'(n);
          den = den * 320'(GAMMA_DEN);
        end
        rhs = rhs << 85;
        lo = 32'd0;
        hi = 32'd131072;
        for (int it = 0; it < 20; it++) begin
          if (lo < hi) begin
            mid = lo + ((hi - lo + 32'd1) >> 1);
            lhs = den;
            for (int k = 0; k < 5; k++) begin
              lhs = lhs * 320'(mid);
            end
            if (lhs <= rhs) begin
              lo = mid;
            end else begin
              hi = mid - 32'd1;
            end
          end
        end
        tab[c] = LIN_W'((lo + 32'd1) >> 1);
      end
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin_tab();

  // sRGB to XYZ matrix, each row divided by the D65 white, Q16
  localparam coef_t KXR = COEF_W'((64'd41240 * 64'd65536 + 64'd47523) / 64'd95047);
  localparam coef_t KXG = COEF_W'((64'd35760 * 64'd65536 + 64'd47523) / 64'd95047);
  localparam coef_t KXB = COEF_W'((64'd18050 * 64'd65536 + 64'd47523) / 64'd95047);
  localparam coef_t KYR = COEF_W'((64'd2126 * 64'd65536 + 64'd5000) / 64'd10000);
  localparam coef_t KYG = COEF_W'((64'd7152 * 64'd65536 + 64'd5000) / 64'd10000);
  localparam coef_t KYB = COEF_W'((64'd722 * 64'd65536 + 64'd5000) / 64'd10000);
  localparam coef_t KZR = COEF_W'((64'd1930 * 64'd65536 + 64'd54441) / 64'd108883);
  localparam coef_t KZG = COEF_W'((64'd11920 * 64'd65536 + 64'd54441) / 64'd108883);
  localparam coef_t KZB = COEF_W'((64'd95050 * 64'd65536 + 64'd54441) / 64'd108883);

  // knee threshold in Q32 and linear-branch offset 16/116 in Q20
  localparam t_val_t KNEE_T = T_W'((64'd8856 << 32) / 64'd1000000);
  localparam f_val_t OFFSET_F = F_W'((64'd16 * 64'd1048576 + 64'd58) / 64'd116);

  // linear branch: floor((7787 t + 2048000) / 4096000) as a multiply by 1/125
  localparam logic [12:0] SLOPE_K = 13'd7787;
  localparam logic [39:0] LIN_BIAS = 40'd2048000;
  localparam logic [25:0] RECIP_125 = 26'(((64'd1 << 32) + 64'd124) / 64'd125);

endpackage

`default_nettype wire

FILE: rtl/s2lab_front.sv
// ----------------------------------------------------------------------------
// s2lab_front: gamma lookup and XYZ matrix
// Three register stages: linear channels, nine products, row sums (t in Q32).
// ----------------------------------------------------------------------------
`default_nettype none

module s2lab_front
  import s2lab_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       en_i,
  input  wire logic [7:0] red_i,
  input  wire logic [7:0] green_i,
  input  wire logic [7:0] blue_i,
  output t_val_t          t_x_o,
  output t_val_t          t_y_o,
  output t_val_t          t_z_o
);

  logic [LIN_W-1:0] lin_r_q, lin_g_q, lin_b_q;
  logic [PROD_W-1:0] p_q [9];
  logic [PROD_W-1:0] p_d [9];
  logic [PROD_W+1:0] sum_x, sum_y, sum_z;
  t_val_t t_x_q, t_y_q, t_z_q;

  // clamp a row sum below 2^34
  function automatic t_val_t clamp_t(input logic [PROD_W+1:0] s);
    t_val_t r;
    if (s[PROD_W+1]) begin
      r = '1;
    end else begin
      r = T_W'(s);
    end
    return r;
  endfunction

  // matrix products
  always_comb begin
    p_d[0] = PROD_W'(lin_r_q) * PROD_W'(KXR);
    p_d[1] = PROD_W'(lin_g_q) * PROD_W'(KXG);
    p_d[2] = PROD_W'(lin_b_q) * PROD_W'(KXB);
    p_d[3] = PROD_W'(lin_r_q) * PROD_W'(KYR);
    p_d[4] = PROD_W'(lin_g_q) * PROD_W'(KYG);
    p_d[5] = PROD_W'(lin_b_q) * PROD_W'(KYB);
    p_d[6] = PROD_W'(lin_r_q) * PROD_W'(KZR);
    p_d[7] = PROD_W'(lin_g_q) * PROD_W'(KZG);
    p_d[8] = PROD_W'(lin_b_q) * PROD_W'(KZB);
  end

  // row sums
  always_comb begin
    sum_x = (PROD_W+2)'(p_q[0]) + (PROD_W+2)'(p_q[1]) + (PROD_W+2)'(p_q[2]);
    sum_y = (PROD_W+2)'(p_q[3]) + (PROD_W+2)'(p_q[4]) + (PROD_W+2)'(p_q[5]);
    sum_z = (PROD_W+2)'(p_q[6]) + (PROD_W+2)'(p_q[7]) + (PROD_W+2)'(p_q[8]);
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lin_r_q <= LIN_TAB[red_i];
      lin_g_q <= LIN_TAB[green_i];
      lin_b_q <= LIN_TAB[blue_i];
      for (int i = 0; i < 9; i++) begin
        p_q[i] <= p_d[i];
      end
      t_x_q <= clamp_t(sum_x);
      t_y_q <= clamp_t(sum_y);
      t_z_q <= clamp_t(sum_z);
    end
  end

  assign t_x_o = t_x_q;
  assign t_y_o = t_y_q;
  assign t_z_o = t_z_q;

endmodule

`default_nettype wire

FILE: rtl/s2lab_knee.sv
// ----------------------------------------------------------------------------
// s2lab_knee: knee function of one channel, t (Q32) to f (Q20)
// A 21-step pipelined cube root runs beside the linear branch; the knee
// compare picks one at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module s2lab_knee
  import s2lab_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   en_i,
  input  wire t_val_t t_i,
  output f_val_t      f_o
);

  localparam int RW = 48;
  localparam int SW = 44;
  localparam int YW = F_W;
  localparam int FDLY = CBRT_STEPS - 2;

  // cube root stage registers
  logic [YW-1:0] y_q [CBRT_STEPS];
  logic [SW-1:0] s_q [CBRT_STEPS];
  logic [RW-1:0] rem_q [CBRT_STEPS];
  t_val_t        tc_q [CBRT_STEPS];
  logic [YW-1:0] y_d [CBRT_STEPS];
  logic [SW-1:0] s_d [CBRT_STEPS];
  logic [RW-1:0] rem_d [CBRT_STEPS];
  t_val_t        tc_d [CBRT_STEPS];

  // linear branch and branch select
  logic [38:0]   lx_q;
  logic [50:0]   lp_q;
  f_val_t        lf_q [FDLY];
  logic          sel_q [CBRT_STEPS];
  logic [39:0]   lz;
  f_val_t        f_q;

  genvar k;
  generate
    for (k = 0; k < CBRT_STEPS; k++) begin : g_step
      logic [YW-1:0] y_p;
      logic [SW-1:0] s_p;
      logic [RW-1:0] rem_p;
      t_val_t        t_p;
      logic [62:0]   v;
      logic [RW-1:0] rem_sh, b;
      logic [YW-1:0] y2;
      logic [SW-1:0] s4;

      if (k == 0) begin : g_first
        assign y_p = '0;
        assign s_p = '0;
        assign rem_p = '0;
        assign t_p = t_i;
      end else begin : g_next
        assign y_p = y_q[k-1];
        assign s_p = s_q[k-1];
        assign rem_p = rem_q[k-1];
        assign t_p = tc_q[k-1];
      end

      // one result bit: try y+1 against the remainder
      always_comb begin
        v = {1'b0, t_p, 28'b0};
        rem_sh = {rem_p[RW-4:0], v[3*(CBRT_STEPS-1-k) +: 3]};
        y2 = {y_p[YW-2:0], 1'b0};
        s4 = {s_p[SW-3:0], 2'b00};
        b = RW'({s4, 1'b0}) + RW'(s4) + RW'({y2, 1'b0}) + RW'(y2) + RW'(1);
        tc_d[k] = t_p;
        if (rem_sh >= b) begin
          rem_d[k] = rem_sh - b;
          y_d[k] = y2 | YW'(1);
          s_d[k] = s4 + SW'({y2, 1'b0}) + SW'(1);
        end else begin
          rem_d[k] = rem_sh;
          y_d[k] = y2;
          s_d[k] = s4;
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          y_q[k] <= y_d[k];
          s_q[k] <= s_d[k];
          rem_q[k] <= rem_d[k];
          tc_q[k] <= tc_d[k];
        end
      end
    end
  endgenerate

  // linear branch: 7787 t, then divide by 4096000 through 1/125
  assign lz = 40'(lx_q) + LIN_BIAS;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lx_q <= 39'(t_i[25:0]) * 39'(SLOPE_K);
      lp_q <= 51'(lz[39:15]) * 51'(RECIP_125);
      lf_q[0] <= F_W'(lp_q[50:32]) + OFFSET_F;
      for (int i = 1; i < FDLY; i++) begin
        lf_q[i] <= lf_q[i-1];
      end
      sel_q[0] <= (t_i > KNEE_T);
      for (int i = 1; i < CBRT_STEPS; i++) begin
        sel_q[i] <= sel_q[i-1];
      end
      f_q <= sel_q[CBRT_STEPS-1] ? y_q[CBRT_STEPS-1] : lf_q[FDLY-1];
    end
  end

  assign f_o = f_q;

endmodule

`default_nettype wire

FILE: rtl/s2lab_back.sv
// ----------------------------------------------------------------------------
// s2lab_back: L*, a*, b* from the knee outputs
// Stage one scales the differences and forms the lightness numerator, stage
// two rounds and saturates into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module s2lab_back
  import s2lab_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire f_val_t        fx_i,
  input  wire f_val_t        fy_i,
  input  wire f_val_t        fz_i,
  output logic [14:0]        lightness_o,
  output logic signed [15:0] green_red_o,
  output logic signed [15:0] blue_yellow_o
);

  localparam int SH = 20 - FRAC_BITS;
  localparam int HALF = 1 << (SH - 1);
  localparam int CAP_RAW = 100 << FRAC_BITS;
  localparam int CAP = (CAP_RAW > 32767) ? 32767 : CAP_RAW;

  logic signed [29:0] lnum_q;
  logic signed [31:0] da_q, db_q;
  logic signed [21:0] dxy, dyz;
  logic [14:0] light_q;
  logic [15:0] a_q, b_q;
  logic [30:0] lrnd;
  logic [14:0] light_d;

  // Q20 to Q(FRAC_BITS), half away from zero, saturated to 16 bits
  function automatic logic [15:0] round_sat(input logic signed [31:0] v);
    logic [31:0] mag;
    logic [32:0] rnd;
    logic [16:0] m;
    logic [15:0] r;
    mag = v[31] ? 32'(-v) : 32'(v);
    rnd = (33'(mag) + 33'(HALF)) >> SH;
    if (v[31]) begin
      m = (rnd > 33'd32768) ? 17'd32768 : 17'(rnd);
      r = 16'(~m + 17'd1);
    end else begin
      m = (rnd > 33'd32767) ? 17'd32767 : 17'(rnd);
      r = 16'(m);
    end
    return r;
  endfunction

  // differences of the knee outputs
  assign dxy = $signed({1'b0, fx_i}) - $signed({1'b0, fy_i});
  assign dyz = $signed({1'b0, fy_i}) - $signed({1'b0, fz_i});

  // lightness rounding and clamping
  always_comb begin
    lrnd = (31'(lnum_q) + 31'(HALF)) >> SH;
    if (lnum_q <= 30'sd0) begin
      light_d = '0;
    end else if (lrnd > 31'(CAP)) begin
      light_d = 15'(CAP);
    end else begin
      light_d = 15'(lrnd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lnum_q <= $signed(30'(fy_i) * 30'd116) - 30'sd16777216;
      da_q <= 32'(dxy) * 32'sd500;
      db_q <= 32'(dyz) * 32'sd200;
      light_q <= light_d;
      a_q <= round_sat(da_q);
      b_q <= round_sat(db_q);
    end
  end

  assign lightness_o = light_q;
  assign green_red_o = $signed(a_q);
  assign blue_yellow_o = $signed(b_q);

endmodule

`default_nettype wire

FILE: rtl/srgb_to_cielab_top.sv
// ----------------------------------------------------------------------------
// srgb_to_cielab_top: sRGB pixel to CIE L*a*b* (D65, 2-degree observer)
// Gamma table, XYZ matrix, pipelined knee function and output rounding.
//
//   channel | direction | handshake        | payload
//   --------+-----------+------------------+---------------------------------
//   pixel   | in        | valid_i, stall_o | red_i, green_i, blue_i
//   lab     | out       | valid_o, stall_i | lightness_o, green_red_o,
//           |           |                  | blue_yellow_o
//
// One pixel per cycle while the output is not stalled; the 21-step cube
// root pipeline makes up most of the pipeline.
// Reset clears the valid bits only; no memory needs clearing.
// A stalled output freezes the whole pipeline and raises stall_o in the
// same cycle; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module srgb_to_cielab_top
  import s2lab_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               stall_o,
  input  wire logic [7:0]    red_i,
  input  wire logic [7:0]    green_i,
  input  wire logic [7:0]    blue_i,
  output logic               valid_o,
  input  wire logic          stall_i,
  output logic [14:0]        lightness_o,
  output logic signed [15:0] green_red_o,
  output logic signed [15:0] blue_yellow_o
);

  localparam int LAT = 3 + CBRT_STEPS + 1 + 2;

  logic en;
  logic [LAT-1:0] vld_q;
  t_val_t t_x, t_y, t_z;
  f_val_t f_x, f_y, f_z;

  // pipeline advances unless a finished result is held
  assign en = !(vld_q[LAT-1] && stall_i);
  assign stall_o = !en;
  assign valid_o = vld_q[LAT-1];

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], valid_i};
    end
  end

  s2lab_front u_front (
    .clk_i   (clk_i),
    .en_i    (en),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .t_x_o   (t_x),
    .t_y_o   (t_y),
    .t_z_o   (t_z)
  );

  s2lab_knee u_knee_x (.clk_i(clk_i), .en_i(en), .t_i(t_x), .f_o(f_x));
  s2lab_knee u_knee_y (.clk_i(clk_i), .en_i(en), .t_i(t_y), .f_o(f_y));
  s2lab_knee u_knee_z (.clk_i(clk_i), .en_i(en), .t_i(t_z), .f_o(f_z));

  s2lab_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .en_i          (en),
    .fx_i          (f_x),
    .fy_i          (f_y),
    .fz_i          (f_z),
    .lightness_o   (lightness_o),
    .green_red_o   (green_red_o),
    .blue_yellow_o (blue_yellow_o)
  );

endmodule

`default_nettype wire

FILE: rtl/s2lab_chk.sv
// ----------------------------------------------------------------------------
// s2lab_chk: port-level checks of the L*a*b* converter
// Watches the handshakes and the lightness range over time.
// ----------------------------------------------------------------------------
`default_nettype none

module s2lab_chk #(
  parameter int FRAC_BITS = 8
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        stall_o,
  input wire logic        valid_o,
  input wire logic        stall_i,
  input wire logic [14:0] lightness_o,
  input wire logic [15:0] green_red_o,
  input wire logic [15:0] blue_yellow_o
);

  localparam int CAP_RAW = 100 << FRAC_BITS;
  localparam int CAP = (CAP_RAW > 32767) ? 32767 : CAP_RAW;

  // a held result stays put
  a_hold_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(lightness_o) && $stable(green_red_o)
      && $stable(blue_yellow_o))
    else $error("result changed while stalled");

  // input stall only comes from a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("input stalled without a held result");

  // an output stall always reaches the input
  a_stall_reach: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |-> stall_o)
    else $error("input not stalled while result held");

  // lightness never above 100
  a_light_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> lightness_o <= 15'(CAP))
    else $error("lightness above range");

endmodule

bind srgb_to_cielab_top s2lab_chk #(
  .FRAC_BITS (FRAC_BITS)
) u_s2lab_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .stall_o       (stall_o),
  .valid_o       (valid_o),
  .stall_i       (stall_i),
  .lightness_o   (lightness_o),
  .green_red_o   (green_red_o),
  .blue_yellow_o (blue_yellow_o)
);

`default_nettype wire

FILE: sim/lab_checker.sv
// ----------------------------------------------------------------------------
// lab_checker: pixel to L*a*b* prediction and result comparison
// Watches both channels. It computes the expected L*a*b* triple for every
// pixel transfer and checks each result transfer against the oldest one.
// ----------------------------------------------------------------------------
module lab_checker #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic        stall_o,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic        valid_o,
  input  logic        stall_i,
  input  logic [14:0] lightness_o,
  input  logic [15:0] green_red_o,
  input  logic [15:0] blue_yellow_o,
  output int          errors_o,
  output int          pending_o
);

  typedef struct packed {
    logic [14:0] lightness;
    logic [15:0] green_red;
    logic [15:0] blue_yellow;
  } lab_t;

  typedef longint unsigned u64_t;

  // D65-normalized matrix in Q16, knee threshold in Q32, 16/116 in Q20
  localparam u64_t MXR = (u64_t'(41240) * 65536 + 47523) / 95047;
  localparam u64_t MXG = (u64_t'(35760) * 65536 + 47523) / 95047;
  localparam u64_t MXB = (u64_t'(18050) * 65536 + 47523) / 95047;
  localparam u64_t MYR = (u64_t'(2126) * 65536 + 5000) / 10000;
  localparam u64_t MYG = (u64_t'(7152) * 65536 + 5000) / 10000;
  localparam u64_t MYB = (u64_t'(722) * 65536 + 5000) / 10000;
  localparam u64_t MZR = (u64_t'(1930) * 65536 + 54441) / 108883;
  localparam u64_t MZG = (u64_t'(11920) * 65536 + 54441) / 108883;
  localparam u64_t MZB = (u64_t'(95050) * 65536 + 54441) / 108883;
  localparam u64_t KNEE_Q32 = (u64_t'(8856) << 32) / 1000000;
  localparam u64_t OFS_Q20 = (u64_t'(16) * 1048576 + 58) / 116;
  localparam int SH = 20 - FRAC_BITS;

  u64_t gamma_lut [256];
  lab_t lab_fifo [$];
  int   mismatches;

  // sRGB gamma curve: largest y with den^12 * y^5 <= n^12 * 2^85, then halved
  function automatic u64_t srgb_to_linear(int code);
    logic [319:0] num, den, trial;
    u64_t y;
    if (code <= 10) return (u64_t'(code) * 655360 + 16473) / 32946;
    num = 320'd1;
    den = 320'd1;
    for (int k = 0; k < 12; k++) begin
      num = num * 320'(1000 * code + 14025);
      den = den * 320'd269025;
    end
    num = num << 85;
    y = 0;
    for (int b = 17; b >= 0; b--) begin
      trial = den;
      for (int k = 0; k < 5; k++) trial = trial * 320'(y | (u64_t'(1) << b));
      if (trial <= num) y = y | (u64_t'(1) << b);
    end
    return (y + 1) >> 1;
  endfunction

  // t in Q32 to f in Q20
  function automatic u64_t knee_f(u64_t t);
    u64_t v, r, c;
    if (t >= (u64_t'(1) << 34)) t = (u64_t'(1) << 34) - 1;
    if (t <= KNEE_Q32) return (((7787 * t) / 1000 + 2048) >> 12) + OFS_Q20;
    v = t << 28;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      c = r | (u64_t'(1) << b);
      if (c * c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic [15:0] round_sat16(longint v);
    u64_t mag;
    mag = (v < 0) ? u64_t'(-v) : u64_t'(v);
    mag = (mag + (u64_t'(1) << (SH - 1))) >> SH;
    if (v < 0) begin
      if (mag > 32768) mag = 32768;
      return 16'(65536 - mag);
    end
    if (mag > 32767) mag = 32767;
    return 16'(mag);
  endfunction

  function automatic lab_t pixel_to_lab(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    u64_t lr, lg, lb, fx, fy, fz, light, cap;
    longint lnum;
    lab_t res;
    lr = gamma_lut[r];
    lg = gamma_lut[g];
    lb = gamma_lut[b];
    fx = knee_f(MXR * lr + MXG * lg + MXB * lb);
    fy = knee_f(MYR * lr + MYG * lg + MYB * lb);
    fz = knee_f(MZR * lr + MZG * lg + MZB * lb);
    lnum = longint'(116 * fy) - longint'(u64_t'(16) << 20);
    cap = u64_t'(100) << FRAC_BITS;
    if (cap > 32767) cap = 32767;
    light = 0;
    if (lnum > 0) begin
      light = (u64_t'(lnum) + (u64_t'(1) << (SH - 1))) >> SH;
      if (light > cap) light = cap;
    end
    res.lightness = 15'(light);
    res.green_red = round_sat16(500 * (longint'(fx) - longint'(fy)));
    res.blue_yellow = round_sat16(200 * (longint'(fy) - longint'(fz)));
    return res;
  endfunction

  initial begin
    mismatches = 0;
    for (int c = 0; c < 256; c++) gamma_lut[c] = srgb_to_linear(c);
  end

  assign errors_o = mismatches;
  assign pending_o = lab_fifo.size();

  // predict on pixel transfer, compare on result transfer
  always @(posedge clk_i) begin
    lab_t want;
    if (rst_ni && valid_i && !stall_o) lab_fifo.push_back(pixel_to_lab(red_i, green_i, blue_i));
    if (rst_ni && valid_o && !stall_i) begin
      if (lab_fifo.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer L=%0d a=%0d b=%0d",
                                       lightness_o, $signed(green_red_o), $signed(blue_yellow_o));
      end else begin
        want = lab_fifo.pop_front();
        if (want.lightness !== lightness_o || want.green_red !== green_red_o ||
            want.blue_yellow !== blue_yellow_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("lab mismatch: expected L=%0d a=%0d b=%0d, got L=%0d a=%0d b=%0d",
                     want.lightness, $signed(want.green_red), $signed(want.blue_yellow),
                     lightness_o, $signed(green_red_o), $signed(blue_yellow_o));
        end
      end
    end
  end

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the sRGB to L*a*b* converter
// Sends directed and random pixels with random idle bursts on both sides;
// the checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WATCHDOG_LIMIT = 4000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [7:0]  red_i = '0, green_i = '0, blue_i = '0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [14:0] lightness_o;
  logic [15:0] green_red_o, blue_yellow_o;
  int          errors, pending;
  bit          quiet = 1'b0;
  int          idle_cycles = 0;

  srgb_to_cielab_top #(.FRAC_BITS(8)) dut (
    .clk_i, .rst_ni, .valid_i, .stall_o, .red_i, .green_i, .blue_i,
    .valid_o, .stall_i, .lightness_o, .green_red_o, .blue_yellow_o
  );

  lab_checker #(.FRAC_BITS(8)) u_checker (
    .clk_i, .rst_ni, .valid_i, .stall_o, .red_i, .green_i, .blue_i,
    .valid_o, .stall_i, .lightness_o, .green_red_o, .blue_yellow_o,
    .errors_o(errors), .pending_o(pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // receiver stall bursts
  always @(posedge clk_i) begin
    if (quiet) begin
      stall_i <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_i <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      stall_i <= 1'b0;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** srgb_to_cielab_top: FAILED **");
      $finish;
    end
  end

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    bit taken;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    red_i <= r;
    green_i <= g;
    blue_i <= b;
    do begin
      @(negedge clk_i);
      taken = !stall_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  function automatic logic [7:0] rand_code();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 12));   // around the linear-segment switch
      1: return 8'($urandom_range(240, 255));
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    logic [7:0] g;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // black, white, primaries, secondaries, codes at the gamma switch, greys and mixed codes
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd10, 8'd10, 8'd10);
    send_pixel(8'd11, 8'd11, 8'd11);
    send_pixel(8'd10, 8'd0, 8'd11);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd170, 8'd85, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd0);
    send_pixel(8'd254, 8'd254, 8'd254);
    send_pixel(8'd255, 8'd0, 8'd0);
    for (int v = 15; v <= 35; v += 5) send_pixel(8'(v), 8'(v), 8'(v));

    // drain before the random part
    valid_i <= 1'b0;
    wait (pending == 0);
    @(posedge clk_i);

    for (int i = 0; i < 600; i++) begin
      if (i == 500) quiet = 1'b1;
      if ($urandom_range(0, 4) == 0) begin
        g = rand_code();
        send_pixel(g, g, g);
      end else begin
        send_pixel(rand_code(), rand_code(), rand_code());
      end
    end
    valid_i <= 1'b0;

    wait (pending == 0);
    repeat (40) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("** srgb_to_cielab_top: PASSED **");
    end else begin
      $display("** srgb_to_cielab_top: FAILED **");
    end
    $finish;
  end

endmodule
